// ----- rtl/bitmap_slot_pool_allocator_assert.svh -----
// Assertion macros shared by the slot pool allocator RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef BITMAP_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BSPA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BSPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bspa_pkg.sv -----
// Shared types and constants for the bitmap slot pool allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package bspa_pkg;

   localparam int MAX_BLOCKS      = 8;
   localparam int SLOTS_PER_BLOCK = 64;
   localparam int BLK_W           = 3;
   localparam int SLOT_W          = 6;
   localparam int CNT_W           = 4;
   localparam int STATUS_W        = 3;
   localparam int GROUP_W         = 8;
   localparam int GROUPS          = SLOTS_PER_BLOCK / GROUP_W;
   localparam int GRP_IDX_W       = 3;
   localparam int BIT_IDX_W       = 3;

   localparam logic [CNT_W-1:0] MAX_ENABLED = CNT_W'(MAX_BLOCKS);

   typedef logic [SLOTS_PER_BLOCK-1:0] map_type;

   typedef enum logic [1:0] {
      CMD_ALLOC      = 2'd0,
      CMD_ALLOC_GROW = 2'd1,
      CMD_FREE       = 2'd2,
      CMD_GROW       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_FULL         = 3'd1,
      ST_WAS_FREE     = 3'd2,
      ST_BAD_HANDLE   = 3'd3,
      ST_GROW_REFUSED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BLOCK,
      S_BYTE,
      S_BIT,
      S_FREE,
      S_GROW,
      S_DONE
   } state_type;

   // One bit update of the bitmap store.
   typedef struct packed {
      logic              en;
      logic              set;
      logic [SLOT_W-1:0] slot;
   } map_wr_type;

endpackage

`default_nettype wire

// ----- rtl/bspa_ffz8.sv -----
// Shared find-first-zero unit over an eight-bit busy vector.
// Depends on bspa_pkg for widths.
`default_nettype none

module bspa_ffz8 (
   input  wire logic [bspa_pkg::GROUP_W-1:0]   busy,
   output logic                                found,
   output logic [bspa_pkg::BIT_IDX_W-1:0]      idx
);

   always_comb begin
      idx = '0;
      // Scan downward so the lowest clear bit wins.
      for (int i = bspa_pkg::GROUP_W - 1; i >= 0; i--) begin
         if (!busy[i]) begin
            idx = bspa_pkg::BIT_IDX_W'(i);
         end
      end
   end

   assign found = ~&busy;

endmodule

`default_nettype wire

// ----- rtl/bspa_maps.sv -----
// Occupancy bitmaps of all blocks with a per-block full flag.
// Depends on bspa_pkg; one block address serves both read and update.
`default_nettype none

module bspa_maps (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bspa_pkg::BLK_W-1:0]    blk,
   input  wire bspa_pkg::map_wr_type          wr,
   output bspa_pkg::map_type                  rd_map,
   output logic [bspa_pkg::MAX_BLOCKS-1:0]    full
);

   bspa_pkg::map_type                maps_ff [bspa_pkg::MAX_BLOCKS];
   logic [bspa_pkg::MAX_BLOCKS-1:0]  full_ff;
   bspa_pkg::map_type                map_in;
   logic                             full_in;

   assign rd_map = maps_ff[blk];
   assign full   = full_ff;

   always_comb begin
      map_in           = rd_map;
      map_in[wr.slot]  = wr.set;
      full_in          = &map_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bspa_pkg::MAX_BLOCKS; b++) begin
            maps_ff[b] <= '0;
         end
         full_ff <= '0;
      end else if (wr.en) begin
         maps_ff[blk] <= map_in;
         full_ff[blk] <= full_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bitmap_slot_pool_allocator.sv -----
// Bitmap slot pool allocator: eight blocks of 64 slots, first-fit allocation.
// Commands arrive on the req_ channel (valid/ready) as allocate, allocate with
// grow, free or grow; each item yields exactly one result on the rsp_ channel
// carrying status, the granted block and slot, and the enabled block count.
// A small sequencer drives one shared find-first-zero unit for each
// allocation: over the per-block full flags, then over the byte-full flags of
// the chosen bitmap, then over the bits of the chosen byte.
// Each command steps through its states in order: an allocate through block,
// byte and bit search and then done, with a repeat of the block search when
// allocate with grow adds a block; free and grow through their own state and
// then done; an allocate that finds the pool full from block search to done.
// One item is worked on at a time: no new item is taken before the last has
// left done, so the search passes and the result handoff set the pace.
// The result sits in an output register: req_ready returns as soon as the
// result is loaded, so the next item is taken while the receiver stalls; a
// further result waits in its final state until the output register is free.
// Synchronous reset clears every bitmap, disables all blocks and drops
// rsp_valid; the block accepts items in the first cycle after reset.
`default_nettype none

module bitmap_slot_pool_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_command,
   input  wire logic [bspa_pkg::BLK_W-1:0]        req_block_index,
   input  wire logic [bspa_pkg::SLOT_W-1:0]       req_slot_index,
   input  wire logic [bspa_pkg::CNT_W-1:0]        req_grow_count,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bspa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bspa_pkg::BLK_W-1:0]             rsp_granted_block,
   output logic [bspa_pkg::SLOT_W-1:0]            rsp_granted_slot,
   output logic [bspa_pkg::CNT_W-1:0]             rsp_enabled_blocks
);

`include "bitmap_slot_pool_allocator_assert.svh"

   bspa_pkg::state_type                  state_ff, state_in;
   bspa_pkg::cmd_type                    cmd_ff, cmd_in;
   bspa_pkg::status_type                 status_ff, status_in;
   logic [bspa_pkg::BLK_W-1:0]           blk_ff, blk_in;
   logic [bspa_pkg::SLOT_W-1:0]          sidx_ff, sidx_in;
   logic [bspa_pkg::CNT_W-1:0]           gcnt_ff, gcnt_in;
   logic [bspa_pkg::GRP_IDX_W-1:0]       grp_ff, grp_in;
   logic [bspa_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [bspa_pkg::CNT_W-1:0]           enabled_ff, enabled_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [bspa_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [bspa_pkg::BLK_W-1:0]           rsp_block_ff, rsp_block_in;
   logic [bspa_pkg::SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [bspa_pkg::CNT_W-1:0]           rsp_enabled_ff, rsp_enabled_in;

   bspa_pkg::map_wr_type                 map_wr;
   bspa_pkg::map_type                    rd_map;
   logic [bspa_pkg::MAX_BLOCKS-1:0]      full;

   logic [bspa_pkg::GROUP_W-1:0]         ffz_busy;
   logic                                 ffz_found;
   logic [bspa_pkg::BIT_IDX_W-1:0]       ffz_idx;

   logic                                 can_grow_one;
   logic                                 free_bad;
   logic [bspa_pkg::CNT_W:0]             grow_sum;
   logic                                 grow_refused;
   logic                                 out_free;
   logic                                 is_alloc;

   bspa_maps u_maps (
      .clock  (clock),
      .reset  (reset),
      .blk    (blk_ff),
      .wr     (map_wr),
      .rd_map (rd_map),
      .full   (full)
   );

   bspa_ffz8 u_ffz (
      .busy  (ffz_busy),
      .found (ffz_found),
      .idx   (ffz_idx)
   );

   // Operand of the shared search unit for the current step.
   always_comb begin
      ffz_busy = '1;
      case (state_ff)
         bspa_pkg::S_BLOCK: begin
            // Blocks that are full or not yet enabled are skipped.
            for (int b = 0; b < bspa_pkg::MAX_BLOCKS; b++) begin
               ffz_busy[b] = full[b] || (bspa_pkg::CNT_W'(b) >= enabled_ff);
            end
         end
         bspa_pkg::S_BYTE: begin
            for (int g = 0; g < bspa_pkg::GROUPS; g++) begin
               ffz_busy[g] = &rd_map[g*bspa_pkg::GROUP_W +: bspa_pkg::GROUP_W];
            end
         end
         bspa_pkg::S_BIT: begin
            ffz_busy = rd_map[grp_ff*bspa_pkg::GROUP_W +: bspa_pkg::GROUP_W];
         end
         default: begin
            ffz_busy = '1;
         end
      endcase
   end

   assign can_grow_one = (cmd_ff == bspa_pkg::CMD_ALLOC_GROW) &&
                         (enabled_ff < bspa_pkg::MAX_ENABLED);
   assign free_bad     = (bspa_pkg::CNT_W'(blk_ff) >= enabled_ff) ||
                         ((bspa_pkg::SLOT_W+1)'(sidx_ff) >=
                          (bspa_pkg::SLOT_W+1)'(bspa_pkg::SLOTS_PER_BLOCK));
   assign grow_sum     = (bspa_pkg::CNT_W+1)'(enabled_ff) + (bspa_pkg::CNT_W+1)'(gcnt_ff);
   assign grow_refused = (gcnt_ff == '0) ||
                         (grow_sum > (bspa_pkg::CNT_W+1)'(bspa_pkg::MAX_BLOCKS));
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign is_alloc     = (cmd_ff == bspa_pkg::CMD_ALLOC) ||
                         (cmd_ff == bspa_pkg::CMD_ALLOC_GROW);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bspa_pkg::S_IDLE: begin
            if (req_valid) begin
               case (bspa_pkg::cmd_type'(req_command))
                  bspa_pkg::CMD_ALLOC, bspa_pkg::CMD_ALLOC_GROW: state_in = bspa_pkg::S_BLOCK;
                  bspa_pkg::CMD_FREE:                            state_in = bspa_pkg::S_FREE;
                  default:                                       state_in = bspa_pkg::S_GROW;
               endcase
            end
         end
         bspa_pkg::S_BLOCK: begin
            if (ffz_found) begin
               state_in = bspa_pkg::S_BYTE;
            end else if (can_grow_one) begin
               state_in = bspa_pkg::S_BLOCK;
            end else begin
               state_in = bspa_pkg::S_DONE;
            end
         end
         bspa_pkg::S_BYTE: state_in = bspa_pkg::S_BIT;
         bspa_pkg::S_BIT:  state_in = bspa_pkg::S_DONE;
         bspa_pkg::S_FREE: state_in = bspa_pkg::S_DONE;
         bspa_pkg::S_GROW: state_in = bspa_pkg::S_DONE;
         bspa_pkg::S_DONE: begin
            if (out_free) begin
               state_in = bspa_pkg::S_IDLE;
            end
         end
         default: state_in = bspa_pkg::S_IDLE;
      endcase
   end

   // Datapath updates and handshake outputs.
   always_comb begin
      req_ready      = 1'b0;
      map_wr         = '0;
      cmd_in         = cmd_ff;
      status_in      = status_ff;
      blk_in         = blk_ff;
      sidx_in        = sidx_ff;
      gcnt_in        = gcnt_ff;
      grp_in         = grp_ff;
      slot_in        = slot_ff;
      enabled_in     = enabled_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_enabled_in = rsp_enabled_ff;
      unique case (state_ff)
         bspa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = bspa_pkg::cmd_type'(req_command);
               status_in = bspa_pkg::ST_OK;
               blk_in    = req_block_index;
               sidx_in   = req_slot_index;
               gcnt_in   = req_grow_count;
               slot_in   = '0;
            end
         end
         bspa_pkg::S_BLOCK: begin
            if (ffz_found) begin
               blk_in = ffz_idx;
            end else if (can_grow_one) begin
               // Every enabled block is full: the fresh block is empty, so
               // the next search pass lands on it.
               enabled_in = enabled_ff + bspa_pkg::CNT_W'(1);
            end else begin
               status_in = bspa_pkg::ST_FULL;
            end
         end
         bspa_pkg::S_BYTE: begin
            grp_in = ffz_idx;
         end
         bspa_pkg::S_BIT: begin
            slot_in     = {grp_ff, ffz_idx};
            map_wr.en   = 1'b1;
            map_wr.set  = 1'b1;
            map_wr.slot = {grp_ff, ffz_idx};
         end
         bspa_pkg::S_FREE: begin
            if (free_bad) begin
               status_in = bspa_pkg::ST_BAD_HANDLE;
            end else if (!rd_map[sidx_ff]) begin
               status_in = bspa_pkg::ST_WAS_FREE;
            end else begin
               map_wr.en   = 1'b1;
               map_wr.set  = 1'b0;
               map_wr.slot = sidx_ff;
            end
         end
         bspa_pkg::S_GROW: begin
            if (grow_refused) begin
               status_in = bspa_pkg::ST_GROW_REFUSED;
            end else begin
               enabled_in = grow_sum[bspa_pkg::CNT_W-1:0];
            end
         end
         bspa_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_enabled_in = enabled_ff;
               if (is_alloc && (status_ff == bspa_pkg::ST_OK)) begin
                  rsp_block_in = blk_ff;
                  rsp_slot_in  = slot_ff;
               end else begin
                  rsp_block_in = '0;
                  rsp_slot_in  = '0;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bspa_pkg::S_IDLE;
         enabled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      status_ff      <= status_in;
      blk_ff         <= blk_in;
      sidx_ff        <= sidx_in;
      gcnt_ff        <= gcnt_in;
      grp_ff         <= grp_in;
      slot_ff        <= slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_enabled_ff <= rsp_enabled_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_block  = rsp_block_ff;
   assign rsp_granted_slot   = rsp_slot_ff;
   assign rsp_enabled_blocks = rsp_enabled_ff;

   `BSPA_ASSERT_IMPLIES(a_enabled_max, 1'b1, enabled_ff <= bspa_pkg::MAX_ENABLED, "too many blocks")
   `BSPA_ASSERT_IMPLIES(a_bit_found, state_ff == bspa_pkg::S_BIT, ffz_found, "chosen byte is full")
   `BSPA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, state_ff != bspa_pkg::S_IDLE, "idle after accept")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for bitmap_slot_pool_allocator: a directed table and then random
// command traffic. A behavioral pool model predicts every result but those of typed table rows.
// Depends on bspa_pkg and the allocator RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bspa_pkg::status_type        status;
      logic [bspa_pkg::BLK_W-1:0]  blk;
      logic [bspa_pkg::SLOT_W-1:0] slot;
      logic [bspa_pkg::CNT_W-1:0]  enabled;
   } grant_type;

   typedef struct packed {
      bspa_pkg::cmd_type           cmd;
      logic [bspa_pkg::BLK_W-1:0]  blk;
      logic [bspa_pkg::SLOT_W-1:0] slot;
      logic [bspa_pkg::CNT_W-1:0]  cnt;
      logic                        typed;
      grant_type                   want;
   } plan_row_type;

   localparam int        RANDOM_ITEMS   = 1900;
   localparam int        CALM_ITEMS     = 150;
   localparam int        WATCHDOG_LIMIT = 1000;
   localparam int        DRAIN_CYCLES   = 20;
   localparam int        PLAN_ROWS      = 21;
   localparam grant_type ANY_GRANT      = '{bspa_pkg::ST_OK, 3'd0, 6'd0, 4'd0};

   // Rows with typed set carry a result that follows directly from the pool contents.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{bspa_pkg::CMD_ALLOC,      3'd7, 6'd63, 4'd15, 1'b1,
        '{bspa_pkg::ST_FULL,         3'd0, 6'd0, 4'd0}},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd0,  4'd0,  1'b1,
        '{bspa_pkg::ST_BAD_HANDLE,   3'd0, 6'd0, 4'd0}},
      '{bspa_pkg::CMD_GROW,       3'd0, 6'd0,  4'd0,  1'b1,
        '{bspa_pkg::ST_GROW_REFUSED, 3'd0, 6'd0, 4'd0}},
      '{bspa_pkg::CMD_GROW,       3'd0, 6'd0,  4'd15, 1'b1,
        '{bspa_pkg::ST_GROW_REFUSED, 3'd0, 6'd0, 4'd0}},
      '{bspa_pkg::CMD_GROW,       3'd0, 6'd0,  4'd9,  1'b1,
        '{bspa_pkg::ST_GROW_REFUSED, 3'd0, 6'd0, 4'd0}},
      '{bspa_pkg::CMD_ALLOC_GROW, 3'd7, 6'd63, 4'd15, 1'b1,
        '{bspa_pkg::ST_OK,           3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_ALLOC,      3'd0, 6'd0,  4'd0,  1'b1,
        '{bspa_pkg::ST_OK,           3'd0, 6'd1, 4'd1}},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd1,  4'd0,  1'b1,
        '{bspa_pkg::ST_OK,           3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd1,  4'd0,  1'b1,
        '{bspa_pkg::ST_WAS_FREE,     3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd63, 4'd0,  1'b1,
        '{bspa_pkg::ST_WAS_FREE,     3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_FREE,       3'd1, 6'd0,  4'd0,  1'b1,
        '{bspa_pkg::ST_BAD_HANDLE,   3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_FREE,       3'd7, 6'd63, 4'd15, 1'b1,
        '{bspa_pkg::ST_BAD_HANDLE,   3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_GROW,       3'd0, 6'd0,  4'd8,  1'b1,
        '{bspa_pkg::ST_GROW_REFUSED, 3'd0, 6'd0, 4'd1}},
      '{bspa_pkg::CMD_GROW,       3'd5, 6'd42, 4'd1,  1'b1,
        '{bspa_pkg::ST_OK,           3'd0, 6'd0, 4'd2}},
      '{bspa_pkg::CMD_ALLOC,      3'd2, 6'd21, 4'd6,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_ALLOC,      3'd0, 6'd0,  4'd0,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd0,  4'd0,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_ALLOC,      3'd0, 6'd0,  4'd0,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_FREE,       3'd1, 6'd0,  4'd0,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_ALLOC_GROW, 3'd0, 6'd0,  4'd0,  1'b0, ANY_GRANT},
      '{bspa_pkg::CMD_FREE,       3'd0, 6'd2,  4'd0,  1'b0, ANY_GRANT}
   };

   logic                          clock;
   logic                          reset              = 1'b1;
   logic                          req_valid          = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_command        = 2'd0;
   logic [bspa_pkg::BLK_W-1:0]    req_block_index    = '0;
   logic [bspa_pkg::SLOT_W-1:0]   req_slot_index     = '0;
   logic [bspa_pkg::CNT_W-1:0]    req_grow_count     = '0;
   logic                          rsp_valid;
   logic                          rsp_ready          = 1'b0;
   logic [bspa_pkg::STATUS_W-1:0] rsp_status;
   logic [bspa_pkg::BLK_W-1:0]    rsp_granted_block;
   logic [bspa_pkg::SLOT_W-1:0]   rsp_granted_slot;
   logic [bspa_pkg::CNT_W-1:0]    rsp_enabled_blocks;

   // Behavioral pool: one occupancy map per block and the enabled block count.
   bspa_pkg::map_type pool_map [bspa_pkg::MAX_BLOCKS];
   int                pool_enabled;
   grant_type         grant_queue [$];

   int mismatches      = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int quiet_cycles    = 0;
   int stall_left      = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   bit calm            = 1'b0;

   bitmap_slot_pool_allocator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_block_index    (req_block_index),
      .req_slot_index     (req_slot_index),
      .req_grow_count     (req_grow_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_block  (rsp_granted_block),
      .rsp_granted_slot   (rsp_granted_slot),
      .rsp_enabled_blocks (rsp_enabled_blocks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest free slot of the first enabled block that is not full; marks it taken.
   function automatic bit first_fit(output logic [bspa_pkg::BLK_W-1:0] blk_o,
                                    output logic [bspa_pkg::SLOT_W-1:0] slot_o);
      blk_o  = '0;
      slot_o = '0;
      for (int b = 0; b < pool_enabled; b++) begin
         if (pool_map[b] != '1) begin
            for (int s = 0; s < bspa_pkg::SLOTS_PER_BLOCK; s++) begin
               if (!pool_map[b][s]) begin
                  pool_map[b][s] = 1'b1;
                  blk_o  = bspa_pkg::BLK_W'(b);
                  slot_o = bspa_pkg::SLOT_W'(s);
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit grow_pool(int count);
      if (count == 0 || pool_enabled + count > bspa_pkg::MAX_BLOCKS)
         return 1'b0;
      for (int b = pool_enabled; b < pool_enabled + count; b++)
         pool_map[b] = '0;
      pool_enabled += count;
      return 1'b1;
   endfunction

   function automatic grant_type predict_grant(bspa_pkg::cmd_type c,
                                               logic [bspa_pkg::BLK_W-1:0] blk,
                                               logic [bspa_pkg::SLOT_W-1:0] slot,
                                               logic [bspa_pkg::CNT_W-1:0] cnt);
      grant_type                   g;
      logic [bspa_pkg::BLK_W-1:0]  gb;
      logic [bspa_pkg::SLOT_W-1:0] gs;
      g = ANY_GRANT;
      gb = '0;
      gs = '0;
      case (c)
         bspa_pkg::CMD_ALLOC: begin
            if (!first_fit(gb, gs))
               g.status = bspa_pkg::ST_FULL;
         end
         bspa_pkg::CMD_ALLOC_GROW: begin
            // Grows by one block only when every enabled block is full.
            if (!first_fit(gb, gs)) begin
               if (!grow_pool(1) || !first_fit(gb, gs))
                  g.status = bspa_pkg::ST_FULL;
            end
         end
         bspa_pkg::CMD_FREE: begin
            if (int'(blk) >= pool_enabled)
               g.status = bspa_pkg::ST_BAD_HANDLE;
            else if (!pool_map[blk][slot])
               g.status = bspa_pkg::ST_WAS_FREE;
            else
               pool_map[blk][slot] = 1'b0;
         end
         default: begin
            if (!grow_pool(int'(cnt)))
               g.status = bspa_pkg::ST_GROW_REFUSED;
         end
      endcase
      g.blk     = gb;
      g.slot    = gs;
      g.enabled = bspa_pkg::CNT_W'(pool_enabled);
      return g;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40)
         $display("tb: mismatch at result %0d: %s", results_checked, what);
   endtask

   task automatic check_grant();
      grant_type want;
      if (grant_queue.size() == 0) begin
         report_mismatch("result with no item outstanding");
         return;
      end
      want = grant_queue.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
      if (rsp_granted_block !== want.blk)
         report_mismatch($sformatf("block %0d, want %0d", rsp_granted_block, want.blk));
      if (rsp_granted_slot !== want.slot)
         report_mismatch($sformatf("slot %0d, want %0d", rsp_granted_slot, want.slot));
      if (rsp_enabled_blocks !== want.enabled)
         report_mismatch($sformatf("enabled %0d, want %0d", rsp_enabled_blocks, want.enabled));
      if (rsp_status < 5)
         status_seen[rsp_status]++;
      results_checked++;
   endtask

   // Result side: checks each accepted result, stalls in bursts and watches for a hang.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_grant();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, grant_queue.size());
            $display("tb: done, errors");
            $finish;
         end
         if (stall_left > 0)
            stall_left--;
         else if (!calm && $urandom_range(7) == 0)
            stall_left = $urandom_range(1, 14);
         rsp_ready <= (stall_left == 0);
      end
   end

   // Presents one item, waits for it to be taken, then records its expected result.
   task automatic send_command(bspa_pkg::cmd_type c, logic [bspa_pkg::BLK_W-1:0] blk,
                               logic [bspa_pkg::SLOT_W-1:0] slot,
                               logic [bspa_pkg::CNT_W-1:0] cnt, logic typed,
                               grant_type want);
      grant_type predicted;
      req_valid       <= 1'b1;
      req_command     <= c;
      req_block_index <= blk;
      req_slot_index  <= slot;
      req_grow_count  <= cnt;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = predict_grant(c, blk, slot, cnt);
      grant_queue.push_back(typed ? want : predicted);
      items_sent++;
      if (!calm && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14))
            @(posedge clock);
      end
   endtask

   initial begin
      bspa_pkg::cmd_type           c;
      logic [bspa_pkg::BLK_W-1:0]  blk;
      logic [bspa_pkg::SLOT_W-1:0] slot;
      logic [bspa_pkg::CNT_W-1:0]  cnt;
      int                          pick;
      int                          w_alloc;
      int                          w_live;
      int                          w_noise;
      int                          b0;
      int                          s0;
      int                          bb;
      int                          ss;
      bit                          found;

      for (int b = 0; b < bspa_pkg::MAX_BLOCKS; b++)
         pool_map[b] = '0;
      pool_enabled = 0;

      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++)
         send_command(PLAN[r].cmd, PLAN[r].blk, PLAN[r].slot, PLAN[r].cnt,
                      PLAN[r].typed, PLAN[r].want);

      // First the pool fills up through allocation, then it churns, then it mostly drains.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < 800) begin
            w_alloc = 80; w_live = 8; w_noise = 6;
         end else if (i < 1400) begin
            w_alloc = 40; w_live = 40; w_noise = 10;
         end else begin
            w_alloc = 25; w_live = 60; w_noise = 10;
         end
         calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
         blk  = bspa_pkg::BLK_W'($urandom_range(7));
         slot = bspa_pkg::SLOT_W'($urandom_range(63));
         cnt  = bspa_pkg::CNT_W'($urandom_range(15));
         pick = $urandom_range(99);
         if (pick < w_alloc) begin
            c = ($urandom_range(1) == 0) ? bspa_pkg::CMD_ALLOC : bspa_pkg::CMD_ALLOC_GROW;
         end else if (pick < w_alloc + w_live + w_noise) begin
            c = bspa_pkg::CMD_FREE;
            if (pick < w_alloc + w_live) begin
               // Look for a handle that is in use, starting at a random place.
               found = 1'b0;
               b0 = $urandom_range(bspa_pkg::MAX_BLOCKS - 1);
               s0 = $urandom_range(bspa_pkg::SLOTS_PER_BLOCK - 1);
               for (int k = 0; k < bspa_pkg::MAX_BLOCKS * bspa_pkg::SLOTS_PER_BLOCK && !found;
                    k++) begin
                  bb = (b0 + k / bspa_pkg::SLOTS_PER_BLOCK) % bspa_pkg::MAX_BLOCKS;
                  ss = (s0 + k) % bspa_pkg::SLOTS_PER_BLOCK;
                  if (bb < pool_enabled && pool_map[bb][ss]) begin
                     found = 1'b1;
                     blk   = bspa_pkg::BLK_W'(bb);
                     slot  = bspa_pkg::SLOT_W'(ss);
                  end
               end
            end
         end else begin
            c = bspa_pkg::CMD_GROW;
            if ($urandom_range(3) != 0)
               cnt = bspa_pkg::CNT_W'($urandom_range(2));
         end
         send_command(c, blk, slot, cnt, 1'b0, ANY_GRANT);
      end
      req_valid <= 1'b0;

      while (grant_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      $display("tb: %0d items sent (%0d from the table), %0d results checked, %0d blocks enabled",
               items_sent, PLAN_ROWS, results_checked, pool_enabled);
      $display("tb: ok %0d, full %0d, was free %0d, bad handle %0d, grow refused %0d",
               status_seen[bspa_pkg::ST_OK], status_seen[bspa_pkg::ST_FULL],
               status_seen[bspa_pkg::ST_WAS_FREE], status_seen[bspa_pkg::ST_BAD_HANDLE],
               status_seen[bspa_pkg::ST_GROW_REFUSED]);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bspa_pkg.sv
rtl/bspa_ffz8.sv
rtl/bspa_maps.sv
rtl/bitmap_slot_pool_allocator.sv
dv/tb.sv
